// File: design/lsp2lpc_pkg.sv
// ----------------------------------------------------------------------------
// lsp2lpc_pkg
// Shared types, widths and fixed-point helpers of the lsp-to-lpc converter.
// ----------------------------------------------------------------------------
package lsp2lpc_pkg;

  localparam int COS_W  = 16;  // input cosine, Q15
  localparam int FAC_W  = 18;  // factor -2c, Q15, holds +2.0
  localparam int POLY_W = 40;  // polynomial coefficient, Q24
  localparam int PROD_W = 43;  // factor times coefficient after the shift
  localparam int ACC_W  = 45;  // update sum before saturation
  localparam int OUT_W  = 32;  // lpc coefficient, Q20
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 4;

  localparam logic signed [POLY_W-1:0] ONE_Q24 = 40'sd16777216;
  localparam logic signed [ACC_W-1:0]  POLY_MAX = 45'sd549755813887;
  localparam logic signed [ACC_W-1:0]  POLY_MIN = -45'sd549755813888;
  localparam logic signed [36:0]       Q20_MAX = 37'sd2147483647;
  localparam logic signed [36:0]       Q20_MIN = -37'sd2147483648;

  // one polynomial update, as classified by the front end
  typedef struct packed {
    logic signed [FAC_W-1:0] factor;
    logic                    odd;
    logic [CNT_W-1:0]        stage;
    logic                    last;
  } cmd_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] lpc_coef;
    logic [IDX_W-1:0]        coef_index;
    logic                    last_coef;
  } res_t;

  function automatic logic signed [POLY_W-1:0] sat_poly(input logic signed [ACC_W-1:0] x);
    logic signed [POLY_W-1:0] r;
    if (x > POLY_MAX) begin
      r = POLY_MAX[POLY_W-1:0];
    end else if (x < POLY_MIN) begin
      r = POLY_MIN[POLY_W-1:0];
    end else begin
      r = x[POLY_W-1:0];
    end
    return r;
  endfunction

  // halve and go from q24 to q20 with floor, then saturate to 32 bits
  function automatic logic signed [OUT_W-1:0] to_q20(input logic signed [41:0] x);
    logic signed [36:0] q;
    logic signed [OUT_W-1:0] r;
    q = 37'(x >>> 5);
    if (q > Q20_MAX) begin
      r = Q20_MAX[OUT_W-1:0];
    end else if (q < Q20_MIN) begin
      r = Q20_MIN[OUT_W-1:0];
    end else begin
      r = q[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/lsp2lpc_queue.sv
// ----------------------------------------------------------------------------
// lsp2lpc_queue
// Small register fifo; depth must be a power of two.
// ----------------------------------------------------------------------------
module lsp2lpc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/lsp2lpc_front.sv
// ----------------------------------------------------------------------------
// lsp2lpc_front
// Takes cosines, turns each into a factor and tags polynomial, stage and end.
// ----------------------------------------------------------------------------
module lsp2lpc_front
  import lsp2lpc_pkg::*;
#(
  parameter int HALF_ORDER = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  input  logic signed [COS_W-1:0] in_lsp_cosine,
  input  logic                    cmd_full,
  output logic                    cmd_push,
  output cmd_t                    cmd
);

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(2 * HALF_ORDER - 1);

  logic [CNT_W-1:0] lsp_count_r;
  logic             is_last;

  assign cmd_push = in_push && !cmd_full;
  assign is_last  = (lsp_count_r == LAST_CNT);

  // -2c is exact; -1.0 becomes +2.0, which needs the extra bit
  always_comb begin
    cmd.factor = FAC_W'(0) - {in_lsp_cosine[COS_W-1], in_lsp_cosine, 1'b0};
    cmd.odd    = lsp_count_r[0];
    cmd.stage  = {1'b0, lsp_count_r[CNT_W-1:1]} + CNT_W'(1);
    cmd.last   = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsp_count_r <= '0;
    end else if (cmd_push) begin
      lsp_count_r <= is_last ? '0 : lsp_count_r + CNT_W'(1);
    end
  end

endmodule

// File: design/lsp2lpc_back.sv
// ----------------------------------------------------------------------------
// lsp2lpc_back
// Polynomial engine: rotates one polynomial through a shared update datapath
// per factor, then walks both polynomials to produce the lpc coefficients.
// ----------------------------------------------------------------------------
module lsp2lpc_back
  import lsp2lpc_pkg::*;
#(
  parameter int HALF_ORDER = 5
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_empty,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  localparam int NC     = HALF_ORDER + 1;
  localparam int STEP_W = $clog2(NC + 1);
  localparam logic [STEP_W-1:0] STEP_END = STEP_W'(NC - 1);
  localparam logic [STEP_W-1:0] EMIT_END = STEP_W'(HALF_ORDER - 1);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_UPDATE  = 4'b0010,
    ST_EMIT_LO = 4'b0100,
    ST_EMIT_HI = 4'b1000
  } back_state_t;

  back_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  cmd_t cmd_r;

  logic signed [POLY_W-1:0] sum_r [NC];
  logic signed [POLY_W-1:0] dif_r [NC];
  logic signed [OUT_W-1:0]  stk_r [HALF_ORDER];
  logic signed [PROD_W-1:0] prod_r;
  logic signed [POLY_W-1:0] prev1_r, prev2_r;

  logic signed [POLY_W-1:0]  head;
  logic signed [57:0]        mul;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [ACC_W-1:0]   acc;
  logic signed [POLY_W-1:0]  upd_val;
  logic signed [40:0]        s_sum, d_dif;
  logic signed [41:0]        s_plus, s_minus;
  logic                      step_done, in_range, take_cmd;

  // update datapath: the product for coefficient j is formed one step early
  assign head     = cmd_r.odd ? dif_r[0] : sum_r[0];
  assign mul      = cmd_r.factor * head;
  assign prod_nxt = PROD_W'(mul >>> 15);
  assign in_range = (step_r != '0) && (CNT_W'(step_r) <= cmd_r.stage);

  always_comb begin
    acc = ACC_W'(head) + ACC_W'(prod_r);
    if (CNT_W'(step_r) == cmd_r.stage) begin
      // the new top coefficient takes twice the one two below (symmetry)
      acc = acc + (ACC_W'(prev2_r) <<< 1);
    end else begin
      acc = acc + ACC_W'(prev2_r);
    end
    upd_val = in_range ? sat_poly(acc) : head;
  end

  // output datapath
  assign s_sum   = 41'(sum_r[0]) + 41'(sum_r[1]);
  assign d_dif   = 41'(dif_r[1]) - 41'(dif_r[0]);
  assign s_plus  = 42'(s_sum) + 42'(d_dif);
  assign s_minus = 42'(s_sum) - 42'(d_dif);

  always_comb begin
    res_push       = 1'b0;
    res.lpc_coef   = to_q20(s_plus);
    res.coef_index = IDX_W'(step_r);
    res.last_coef  = 1'b0;
    case (state_r)
      ST_EMIT_LO: begin
        res_push = !res_full;
      end
      ST_EMIT_HI: begin
        res_push       = !res_full;
        res.lpc_coef   = stk_r[0];
        res.coef_index = IDX_W'(HALF_ORDER) + IDX_W'(step_r);
        res.last_coef  = (step_r == EMIT_END);
      end
      default: begin
      end
    endcase
  end

  assign step_done = (step_r == STEP_END);
  // a new factor is taken when idle or right as the previous one finishes, unless that one closes a frame
  assign take_cmd  = !cmd_empty &&
                     ((state_r == ST_IDLE) ||
                      ((state_r == ST_UPDATE) && step_done && !cmd_r.last));
  assign cmd_pop   = take_cmd;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (take_cmd) begin
          state_nxt = ST_UPDATE;
          step_nxt  = '0;
        end
      end
      ST_UPDATE: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_done) begin
          step_nxt = '0;
          if (cmd_r.last) begin
            state_nxt = ST_EMIT_LO;
          end else if (!take_cmd) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT_LO: begin
        if (res_push) begin
          step_nxt = step_r + STEP_W'(1);
          if (step_r == EMIT_END) begin
            step_nxt  = '0;
            state_nxt = ST_EMIT_HI;
          end
        end
      end
      ST_EMIT_HI: begin
        if (res_push) begin
          step_nxt = step_r + STEP_W'(1);
          if (step_r == EMIT_END) begin
            step_nxt  = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_cmd) begin
      cmd_r <= cmd;
    end
    if (take_cmd) begin
      prod_r  <= '0;
      prev1_r <= '0;
      prev2_r <= '0;
    end else if (state_r == ST_UPDATE) begin
      prod_r  <= prod_nxt;
      prev1_r <= head;
      prev2_r <= prev1_r;
    end
  end

  // polynomial rotation: the coefficient in work always sits at entry 0
  always_ff @(posedge clk) begin
    if (!rst_n || ((state_r == ST_EMIT_HI) && res_push && (step_r == EMIT_END))) begin
      for (int k = 1; k < NC; k++) begin
        sum_r[k] <= '0;
        dif_r[k] <= '0;
      end
      sum_r[0] <= ONE_Q24;
      dif_r[0] <= ONE_Q24;
    end else if (state_r == ST_UPDATE) begin
      if (cmd_r.odd) begin
        for (int k = 0; k < NC - 1; k++) begin
          dif_r[k] <= dif_r[k+1];
        end
        dif_r[NC-1] <= upd_val;
      end else begin
        for (int k = 0; k < NC - 1; k++) begin
          sum_r[k] <= sum_r[k+1];
        end
        sum_r[NC-1] <= upd_val;
      end
    end else if ((state_r == ST_EMIT_LO) && res_push) begin
      for (int k = 0; k < NC - 1; k++) begin
        sum_r[k] <= sum_r[k+1];
        dif_r[k] <= dif_r[k+1];
      end
      sum_r[NC-1] <= sum_r[0];
      dif_r[NC-1] <= dif_r[0];
    end
  end

  // upper half comes out in reverse order, so it goes through a stack
  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT_LO) && res_push) begin
      for (int k = HALF_ORDER - 1; k > 0; k--) begin
        stk_r[k] <= stk_r[k-1];
      end
      stk_r[0] <= to_q20(s_minus);
    end else if ((state_r == ST_EMIT_HI) && res_push) begin
      for (int k = 0; k < HALF_ORDER - 1; k++) begin
        stk_r[k] <= stk_r[k+1];
      end
    end
  end

endmodule

// File: design/lsp_to_lpc_converter.sv
// ----------------------------------------------------------------------------
// lsp_to_lpc_converter
// Converts a frame of line spectral pair cosines into lpc coefficients.
// ----------------------------------------------------------------------------
// each cosine is rotated through the single update datapath, one polynomial
//   coefficient at a time; within a frame the next cosine is taken as the previous one finishes
// the back end takes a cosine from the command queue when it is idle or finishing the previous one; after the
//   last one of a frame the results come out one per cycle while the result queue has room
// reset: synchronous, active low; clears both queues, the frame count and
//   restores both polynomials to 1.0
module lsp_to_lpc_converter
  import lsp2lpc_pkg::*;
#(
  parameter int HALF_ORDER = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  input  logic signed [COS_W-1:0] in_lsp_cosine,
  output logic                    in_full,
  input  logic                    out_pop,
  output logic                    out_empty,
  output logic signed [OUT_W-1:0] out_lpc_coef,
  output logic [IDX_W-1:0]        out_coef_index,
  output logic                    out_last_coef
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  cmd_t cmd_in, cmd_head;
  res_t res_in, res_head;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic res_push, res_full;
  logic [CMD_W-1:0] cmd_head_bits;
  logic [RES_W-1:0] res_head_bits;

  assign in_full = cmd_full;

  lsp2lpc_front #(.HALF_ORDER(HALF_ORDER)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_lsp_cosine(in_lsp_cosine),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  lsp2lpc_queue #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd_in),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .pop_data (cmd_head_bits),
    .empty    (cmd_empty)
  );

  assign cmd_head = cmd_t'(cmd_head_bits);

  lsp2lpc_back #(.HALF_ORDER(HALF_ORDER)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(cmd_empty),
    .cmd      (cmd_head),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  lsp2lpc_queue #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_in),
    .full     (res_full),
    .pop      (out_pop),
    .pop_data (res_head_bits),
    .empty    (out_empty)
  );

  assign res_head       = res_t'(res_head_bits);
  assign out_lpc_coef   = res_head.lpc_coef;
  assign out_coef_index = res_head.coef_index;
  assign out_last_coef  = res_head.last_coef;

  a_cmd_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full)
    else $error("command queue written while full");

  a_res_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result queue written while full");

  a_last_marks_end : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_last_coef == (out_coef_index == IDX_W'(2 * HALF_ORDER - 1))))
    else $error("last flag does not match the final coefficient index");

  a_pop_only_when_queued : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("back end took a command from an empty queue");

endmodule

// File: tb/lsp_to_lpc_converter_tb.sv
// ----------------------------------------------------------------------------
// lsp_to_lpc_converter_tb
// Drives frames of ten lsp cosines through the converter and checks every
// lpc coefficient, against typed-in values for two simple frames and a
// bit-accurate fixed-point predictor for the rest, under random push/pop
// gaps, a long output stall and drain pauses.
// ----------------------------------------------------------------------------
module lsp_to_lpc_converter_tb
  import lsp2lpc_pkg::*;
();

  localparam int HALF     = 5;
  localparam int ORDER    = 2 * HALF;
  localparam int DIR_N    = 25;
  localparam int Q20_ONE  = 1 << 20;
  localparam int HOLD_LEN = 600;
  localparam int LIMIT    = 200000;

  typedef enum logic [1:0] {EXP_PREDICT, EXP_ZERO_FRAME, EXP_NEG_ONE_FRAME} exp_src_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_push = 1'b0;
  logic signed [COS_W-1:0] in_lsp_cosine = '0;
  logic                    in_full;
  logic                    out_pop = 1'b0;
  logic                    out_empty;
  logic signed [OUT_W-1:0] out_lpc_coef;
  logic [IDX_W-1:0]        out_coef_index;
  logic                    out_last_coef;

  lsp_to_lpc_converter u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_lsp_cosine  (in_lsp_cosine),
    .in_full        (in_full),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_lpc_coef   (out_lpc_coef),
    .out_coef_index (out_coef_index),
    .out_last_coef  (out_last_coef)
  );

  // directed frames: all-zero cosines, all cosines at -1.0, then a partial
  // frame of extremes that the random part completes
  logic [COS_W-1:0] dir_cos [DIR_N] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
    16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
    16'h7fff, 16'h8001, 16'h0001, 16'hffff, 16'h8000
  };
  exp_src_t dir_exp [DIR_N] = '{
    EXP_PREDICT, EXP_PREDICT, EXP_PREDICT, EXP_PREDICT, EXP_PREDICT,
    EXP_PREDICT, EXP_PREDICT, EXP_PREDICT, EXP_PREDICT, EXP_ZERO_FRAME,
    EXP_PREDICT, EXP_PREDICT, EXP_PREDICT, EXP_PREDICT, EXP_PREDICT,
    EXP_PREDICT, EXP_PREDICT, EXP_PREDICT, EXP_PREDICT, EXP_NEG_ONE_FRAME,
    EXP_PREDICT, EXP_PREDICT, EXP_PREDICT, EXP_PREDICT, EXP_PREDICT
  };
  // (1+z^-2)^5 per polynomial
  int zero_frame_q20 [ORDER] = '{
    0, 5 * Q20_ONE, 0, 10 * Q20_ONE, 0, 10 * Q20_ONE, 0, 5 * Q20_ONE, 0, Q20_ONE
  };
  // (1+z^-1)^10 binomials
  int neg_one_frame_q20 [ORDER] = '{
    10 * Q20_ONE, 45 * Q20_ONE, 120 * Q20_ONE, 210 * Q20_ONE, 252 * Q20_ONE,
    210 * Q20_ONE, 120 * Q20_ONE, 45 * Q20_ONE, 10 * Q20_ONE, Q20_ONE
  };

  // predictor state: [0] sum polynomial P, [1] difference polynomial Q, q24
  logic signed [POLY_W-1:0] lsp_poly [2][HALF+1];
  logic [CNT_W-1:0]         cos_count;
  logic signed [OUT_W-1:0]  frame_lpc [ORDER];

  res_t lpc_expect_q [$];
  int   phase = 0;
  int   err_cnt = 0;
  int   items_sent = 0;
  int   coefs_seen = 0;
  int   cycles = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [POLY_W-1:0] clamp_q24(input longint x);
    if (x > POLY_MAX) return POLY_MAX[POLY_W-1:0];
    if (x < POLY_MIN) return POLY_MIN[POLY_W-1:0];
    return x[POLY_W-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] q24_to_lpc(input longint x);
    longint q;
    q = x >>> 5;
    if (q > Q20_MAX) return Q20_MAX[OUT_W-1:0];
    if (q < Q20_MIN) return Q20_MIN[OUT_W-1:0];
    return q[OUT_W-1:0];
  endfunction

  function automatic void clear_polys();
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k <= HALF; k++) lsp_poly[s][k] = '0;
      lsp_poly[s][0] = ONE_Q24;
    end
    cos_count = '0;
  endfunction

  // multiply one polynomial by (1 + v z^-1 + z^-2), keeping the low half
  function automatic void grow_poly(input int sel, input longint v, input int stage);
    longint acc;
    int     j;
    acc = (v * longint'(lsp_poly[sel][stage-1])) >>> 15;
    if (stage >= 2) acc += 2 * longint'(lsp_poly[sel][stage-2]);
    lsp_poly[sel][stage] = clamp_q24(acc);
    for (j = stage - 1; j >= 1; j--) begin
      acc = longint'(lsp_poly[sel][j]) + ((v * longint'(lsp_poly[sel][j-1])) >>> 15);
      if (j >= 2) acc += longint'(lsp_poly[sel][j-2]);
      lsp_poly[sel][j] = clamp_q24(acc);
    end
  endfunction

  // returns 1 when this cosine closes a frame; frame_lpc then holds the result
  function automatic bit predict_cosine(input logic signed [COS_W-1:0] c);
    longint s;
    longint d;
    grow_poly(int'(cos_count[0]), -2 * longint'(c), int'(cos_count >> 1) + 1);
    if (cos_count != CNT_W'(ORDER - 1)) begin
      cos_count++;
      return 1'b0;
    end
    for (int i = 0; i < HALF; i++) begin
      s = longint'(lsp_poly[0][i+1]) + longint'(lsp_poly[0][i]);
      d = longint'(lsp_poly[1][i+1]) - longint'(lsp_poly[1][i]);
      frame_lpc[i]           = q24_to_lpc(s + d);
      frame_lpc[ORDER-1-i]   = q24_to_lpc(s - d);
    end
    clear_polys();
    return 1'b1;
  endfunction

  task automatic offer_cosine(input logic signed [COS_W-1:0] c, input exp_src_t src);
    int pct;
    res_t r;
    pct = (phase == 0) ? 12 : (phase == 1) ? 83 : 0;
    while ($urandom_range(99) < pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push       <= 1'b1;
    in_lsp_cosine <= c;
    do @(posedge clk); while (in_full);
    items_sent++;
    if (predict_cosine(c)) begin
      for (int i = 0; i < ORDER; i++) begin
        r.lpc_coef   = (src == EXP_ZERO_FRAME)    ? zero_frame_q20[i] :
                       (src == EXP_NEG_ONE_FRAME) ? neg_one_frame_q20[i] : frame_lpc[i];
        r.coef_index = IDX_W'(i);
        r.last_coef  = (i == ORDER - 1);
        lpc_expect_q.push_back(r);
      end
    end
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (lpc_expect_q.size() != 0);
  endtask

  function automatic logic signed [COS_W-1:0] rand_cosine();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          3: return 16'shffff;
          default: return 16'sh0001;
        endcase
      end
      1, 2: return COS_W'($signed($urandom_range(2047)) - 1024);
      default: return COS_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic report(input string what, input longint e, input longint a);
    err_cnt++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, e, a);
  endtask

  // result side: check each transfer, then decide the next pop
  always @(posedge clk) begin
    res_t exp_c;
    if (rst_n && out_pop && !out_empty) begin
      coefs_seen++;
      if (lpc_expect_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected coefficient %0d at index %0d", $time,
                 out_lpc_coef, out_coef_index);
      end else begin
        exp_c = lpc_expect_q.pop_front();
        if (exp_c.lpc_coef !== out_lpc_coef)
          report("lpc_coef", exp_c.lpc_coef, out_lpc_coef);
        if (exp_c.coef_index !== out_coef_index)
          report("coef_index", exp_c.coef_index, out_coef_index);
        if (exp_c.last_coef !== out_last_coef)
          report("last_coef", exp_c.last_coef, out_last_coef);
      end
    end
    if (phase == 2 && !hold_done) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= ((phase == 0) ? 83 : (phase == 1) ? 12 : 0));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("%0t: timeout with %0d coefficients outstanding", $time, lpc_expect_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int phase_len [3] = '{145, 150, 150};
    clear_polys();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k < DIR_N; k++) offer_cosine(dir_cos[k], dir_exp[k]);
    for (int p = 0; p < 3; p++) begin
      // drain between phases so the sender sees an empty pipeline
      if (p > 0) wait_drained();
      phase = p;
      for (int k = 0; k < phase_len[p]; k++) offer_cosine(rand_cosine(), EXP_PREDICT);
    end
    wait_drained();
    repeat (30) @(posedge clk);
    $display("covered %0d cosines (%0d frames) and %0d coefficient transfers,",
             items_sent, items_sent / ORDER, coefs_seen);
    $display("under three gap mixes, a %0d-cycle output stall and drain pauses", HOLD_LEN);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
